@@ sv/cetm_pkg.sv @@
package cetm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_MINUTE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MDAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WDAY   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BLANK = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic       fire;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic [5:0] cur_minute;
		logic [4:0] cur_hour;
		logic [4:0] cur_mday;
		logic [3:0] cur_month;
		logic [2:0] cur_wday;
	} sched_time_t;

	typedef enum logic [2:0] {
		CK_DIGIT,
		CK_STAR,
		CK_COMMA,
		CK_DASH,
		CK_BLANK,
		CK_EOL,
		CK_HASH,
		CK_OTHER
	} char_kind_t;

	typedef struct packed {
		char_kind_t kind;
		logic [3:0] digit;
		logic       last_char;
	} class_item_t;

endpackage

@@ sv/cetm_front.sv @@
module cetm_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  cetm_pkg::in_item_t in_data,
	input  logic               q_full,
	output logic               q_push,
	output cetm_pkg::class_item_t q_item
);
	import cetm_pkg::*;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	logic [7:0] ch;
	logic [7:0] ch_off;

	assign ch     = in_data.char_code;
	assign ch_off = ch - CH_ZERO;

	always_comb begin
		q_item.last_char = in_data.last_char;
		q_item.digit     = ch_off[3:0];
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			q_item.kind = CK_DIGIT;
		end else if (ch == CH_STAR) begin
			q_item.kind = CK_STAR;
		end else if (ch == CH_COMMA) begin
			q_item.kind = CK_COMMA;
		end else if (ch == CH_DASH) begin
			q_item.kind = CK_DASH;
		end else if (ch == CH_SPACE || ch == CH_TAB) begin
			q_item.kind = CK_BLANK;
		end else if (ch == CH_NUL || ch == CH_LF) begin
			q_item.kind = CK_EOL;
		end else if (ch == CH_HASH) begin
			q_item.kind = CK_HASH;
		end else begin
			q_item.kind = CK_OTHER;
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

@@ sv/cetm_queue.sv @@
module cetm_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cetm_pkg::class_item_t wr_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  rd_valid,
	output cetm_pkg::class_item_t rd_item
);
	import cetm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	class_item_t    mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/cetm_back.sv @@
module cetm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cetm_pkg::sched_time_t sched_time,
	input  logic                  q_valid,
	input  cetm_pkg::class_item_t q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output cetm_pkg::out_item_t   out_data
);
	import cetm_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_STAR,
		PH_FIRST,
		PH_LIST,
		PH_COMMA,
		PH_DASH,
		PH_HIGH,
		PH_BAD
	} phase_t;

	// field index past the five schedule fields
	localparam logic [2:0] IDX_ALL   = 3'd5;
	localparam logic [2:0] IDX_SHORT = 3'd6;

	typedef struct packed {
		logic [2:0] fi;
		phase_t     ph;
		logic [7:0] acc;
		logic       hit;
		logic       am;
		logic       start;
		logic       cmt;
	} line_t;

	localparam line_t LINE_RST = '{
		fi: 3'd0, ph: PH_START, acc: 8'd0, hit: 1'b0, am: 1'b1, start: 1'b1, cmt: 1'b0
	};

	line_t     st_q;
	line_t     st_d;
	out_item_t res_d;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic [7:0] cur;
	logic      first;

	function automatic logic [7:0] add_digit(logic [7:0] acc, logic [3:0] d);
		logic [11:0] v;
		v = 12'(acc) * 12'd10 + 12'(d);
		return (v > 12'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic line_t close_field(line_t s, logic [7:0] c);
		logic m;
		case (s.ph)
			PH_STAR:          m = 1'b1;
			PH_FIRST, PH_LIST: m = s.hit || (s.acc == c);
			PH_HIGH:          m = s.hit && (c <= s.acc);
			default:          m = 1'b0;
		endcase
		if (s.fi < IDX_ALL) begin
			s.am = s.am && m;
			s.fi = s.fi + 3'd1;
		end
		s.ph  = PH_START;
		s.acc = '0;
		s.hit = 1'b0;
		return s;
	endfunction

	always_comb begin
		case (st_q.fi)
			3'd0:    cur = 8'(sched_time.cur_minute);
			3'd1:    cur = 8'(sched_time.cur_hour);
			3'd2:    cur = 8'(sched_time.cur_mday);
			3'd3:    cur = 8'(sched_time.cur_month);
			3'd4:    cur = 8'(sched_time.cur_wday);
			default: cur = 8'd0;
		endcase
	end

	always_comb begin
		st_d       = st_q;
		first      = st_q.start;
		st_d.start = 1'b0;
		if (!st_q.cmt && st_q.fi < IDX_ALL) begin
			case (q_item.kind)
				CK_HASH: begin
					if (first) begin
						st_d.cmt = 1'b1;
					end else begin
						st_d.ph = PH_BAD;
					end
				end
				CK_EOL: begin
					// NUL/LF ends the content; first byte means blank line
					if (first) begin
						st_d.cmt = 1'b1;
					end else begin
						if (st_d.ph != PH_START) begin
							st_d = close_field(st_d, cur);
						end
						if (st_d.fi < IDX_ALL) begin
							st_d.fi = IDX_SHORT;
						end
					end
				end
				CK_BLANK: begin
					if (st_d.ph != PH_START) begin
						st_d = close_field(st_d, cur);
					end
				end
				CK_DIGIT: begin
					case (st_q.ph)
						PH_START: begin
							st_d.acc = add_digit(8'd0, q_item.digit);
							st_d.ph  = PH_FIRST;
						end
						PH_FIRST, PH_LIST, PH_HIGH: begin
							st_d.acc = add_digit(st_q.acc, q_item.digit);
						end
						PH_COMMA: begin
							st_d.acc = add_digit(8'd0, q_item.digit);
							st_d.ph  = PH_LIST;
						end
						PH_DASH: begin
							st_d.acc = add_digit(8'd0, q_item.digit);
							st_d.ph  = PH_HIGH;
						end
						default: st_d.ph = PH_BAD;
					endcase
				end
				CK_STAR: begin
					st_d.ph = (st_q.ph == PH_START) ? PH_STAR : PH_BAD;
				end
				CK_COMMA: begin
					if (st_q.ph == PH_FIRST || st_q.ph == PH_LIST) begin
						st_d.hit = st_q.hit || (st_q.acc == cur);
						st_d.acc = '0;
						st_d.ph  = PH_COMMA;
					end else begin
						st_d.ph = PH_BAD;
					end
				end
				CK_DASH: begin
					// range: remember low <= current
					if (st_q.ph == PH_FIRST) begin
						st_d.hit = (cur >= st_q.acc);
						st_d.acc = '0;
						st_d.ph  = PH_DASH;
					end else begin
						st_d.ph = PH_BAD;
					end
				end
				default: st_d.ph = PH_BAD;
			endcase
		end

		res_d.fire   = 1'b0;
		res_d.status = ST_OK;
		if (q_item.last_char) begin
			if (!st_d.cmt && st_d.fi < IDX_ALL && st_d.ph != PH_START) begin
				st_d = close_field(st_d, cur);
			end
			if (st_d.cmt) begin
				res_d.status = ST_BLANK;
			end else if (st_d.fi == IDX_ALL) begin
				res_d.fire = st_d.am;
			end else begin
				res_d.status = ST_SHORT;
			end
			st_d = LINE_RST;
		end
	end

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last_char) begin
			out_data_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= LINE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				st_q <= st_d;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= q_pop && q_item.last_char;
			end
		end
	end

endmodule

@@ sv/cron_entry_time_matcher.sv @@
// A line's result is registered: its last byte passes through the queue and then
// the result register, held back while bytes wait ahead of it or the result register is not free.
// Throughput: one byte per cycle while the queue is not full; the back-end parser
// retires one queued byte per cycle, limited only by the result register being taken.
// Reset (arst_n low, async): queue empty, line state cleared, no result pending,
// time registers at minute 0, hour 0, day 1, month 1, weekday 0.
module cron_entry_time_matcher #(
	parameter int QDEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  cetm_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output cetm_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [cetm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cetm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cetm_pkg::*;

	sched_time_t sched_time_q;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_valid;
	class_item_t q_wr_item;
	class_item_t q_rd_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_time_q.cur_minute <= 6'd0;
			sched_time_q.cur_hour   <= 5'd0;
			sched_time_q.cur_mday   <= 5'd1;
			sched_time_q.cur_month  <= 4'd1;
			sched_time_q.cur_wday   <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MINUTE: sched_time_q.cur_minute <= cfg_data[5:0];
				REG_HOUR:   sched_time_q.cur_hour   <= cfg_data[4:0];
				REG_MDAY:   sched_time_q.cur_mday   <= cfg_data[4:0];
				REG_MONTH:  sched_time_q.cur_month  <= cfg_data[3:0];
				REG_WDAY:   sched_time_q.cur_wday   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	cetm_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_wr_item)
	);

	cetm_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_item  (q_wr_item),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	cetm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sched_time (sched_time_q),
		.q_valid    (q_valid),
		.q_item     (q_rd_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	a_fire_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fire |-> out_data.status == ST_OK)
		else $error("fire set on a non-ok line");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_BLANK ||
			out_data.status == ST_SHORT))
		else $error("bad status code");

	a_stall_means_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_valid)
		else $error("input stalled with empty queue");

	a_cfg_mday: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_MDAY |=> sched_time_q.cur_mday == $past(cfg_data[4:0]))
		else $error("day register write lost");

endmodule
